// ----- hdl/wsbt_pkg.sv -----
// wsbt_pkg: shared types and constants for the wheel speed balance trim unit
// used by wsbt_regs, wsbt_div and wheel_speed_balance_trim_unit
`timescale 1ns / 1ps
package wsbt_pkg;

    localparam int DUTY_W   = 8;
    localparam int SPEED_W  = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [DUTY_W-1:0]  REF_DUTY_RESET  = 8'd180;
    localparam logic [SPEED_W-1:0] NUMERATOR_RESET = 16'd14400;
    localparam logic [SPEED_W-1:0] SPEED_SAT       = 16'hFFFF;

    localparam logic REG_REF_DUTY   = 1'b0;
    localparam logic REG_SPEED_NUM  = 1'b1;

    typedef struct packed {
        logic [DUTY_W-1:0]  ref_duty;
        logic [SPEED_W-1:0] speed_numerator;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [SPEED_W-1:0] dividend;
        logic [SPEED_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SPEED_W-1:0] quotient;
    } div_stat_t;

endpackage

// ----- hdl/wheel_speed_balance_trim_unit.sv -----
// wheel_speed_balance_trim_unit: top level, sequencer around one shared divider
// each accepted input runs two divisions on the single serial divider, left period
// first and then right, each with a load and a done step, then the output update
// one transaction at a time, s_ready is low from accept until the result is registered,
// and while an older result waits on m_ready the new one waits in ST_DONE with s_ready low
// aresetn synchronous active low: trim and previous speeds clear, registers
// return to ref_duty 180 and speed_numerator 14400
`timescale 1ns / 1ps
module wheel_speed_balance_trim_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsbt_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsbt_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsbt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wsbt_pkg::SPEED_W-1:0]  s_left_period,
    input  logic [wsbt_pkg::SPEED_W-1:0]  s_right_period,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wsbt_pkg::DUTY_W-1:0]   m_left_duty,
    output logic [wsbt_pkg::DUTY_W-1:0]   m_right_duty,
    output logic signed [7:0]             m_trim_now,
    output logic [wsbt_pkg::SPEED_W-1:0]  m_left_speed,
    output logic [wsbt_pkg::SPEED_W-1:0]  m_right_speed,
    output logic [7:0]                    m_left_pair_sum,
    output logic [7:0]                    m_right_pair_sum
);
    import wsbt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEFT,
        ST_RIGHT,
        ST_DONE
    } state_t;

    state_t             state_reg;
    cfg_t               cfg;
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic               start_reg;
    logic [SPEED_W-1:0] lp_reg, rp_reg;
    logic [SPEED_W-1:0] ls_reg, rs_reg;
    logic [SPEED_W-1:0] speed_now;
    logic [7:0]         trim_reg, trim_next;
    logic [7:0]         last_l_reg, last_r_reg;
    logic               m_valid_reg;
    logic [DUTY_W-1:0]  left_duty_reg, right_duty_reg;
    logic [7:0]         trim_out_reg;
    logic [SPEED_W-1:0] left_speed_reg, right_speed_reg;
    logic [7:0]         left_sum_reg, right_sum_reg;
    logic               s_accept;

    wsbt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsbt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign div_ctrl.start    = start_reg;
    assign div_ctrl.dividend = cfg.speed_numerator;
    assign div_ctrl.divisor  = (state_reg == ST_LEFT) ? lp_reg : rp_reg;

    always_comb begin
        if (state_reg == ST_LEFT) begin
            speed_now = (lp_reg == '0) ? SPEED_SAT : div_stat.quotient;
        end else begin
            speed_now = (rp_reg == '0) ? SPEED_SAT : div_stat.quotient;
        end
    end

    always_comb begin
        if (rs_reg < ls_reg) begin
            trim_next = trim_reg + 8'd1;
        end else if (rs_reg > ls_reg) begin
            trim_next = trim_reg - 8'd1;
        end else begin
            trim_next = trim_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            trim_reg    <= '0;
            last_l_reg  <= '0;
            last_r_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        lp_reg    <= s_left_period;
                        rp_reg    <= s_right_period;
                        start_reg <= 1'b1;
                        state_reg <= ST_LEFT;
                    end
                end
                ST_LEFT: begin
                    if (div_stat.done) begin
                        ls_reg    <= speed_now;
                        start_reg <= 1'b1;
                        state_reg <= ST_RIGHT;
                    end
                end
                ST_RIGHT: begin
                    if (div_stat.done) begin
                        rs_reg    <= speed_now;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        trim_reg        <= trim_next;
                        last_l_reg      <= ls_reg[7:0];
                        last_r_reg      <= rs_reg[7:0];
                        m_valid_reg     <= 1'b1;
                        left_duty_reg   <= cfg.ref_duty;
                        right_duty_reg  <= cfg.ref_duty + trim_next;
                        trim_out_reg    <= trim_next;
                        left_speed_reg  <= ls_reg;
                        right_speed_reg <= rs_reg;
                        left_sum_reg    <= ls_reg[7:0] + last_l_reg;
                        right_sum_reg   <= rs_reg[7:0] + last_r_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_duty      = left_duty_reg;
    assign m_right_duty     = right_duty_reg;
    assign m_trim_now       = trim_out_reg;
    assign m_left_speed     = left_speed_reg;
    assign m_right_speed    = right_speed_reg;
    assign m_left_pair_sum  = left_sum_reg;
    assign m_right_pair_sum = right_sum_reg;

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready && start_reg)
        else $error("input accepted without starting the divider");

    a_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_LEFT || state_reg == ST_RIGHT))
        else $error("divider finished outside a division state");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !div_stat.busy)
        else $error("divider started while busy");

    a_trim_tracks_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=>
            m_valid && (m_trim_now == trim_reg))
        else $error("result trim differs from stored trim");

endmodule

// ----- hdl/wsbt_regs.sv -----
// wsbt_regs: apb configuration registers (reference duty, speed numerator)
// depends on wsbt_pkg
`timescale 1ns / 1ps
module wsbt_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsbt_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsbt_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsbt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output wsbt_pkg::cfg_t                cfg
);
    import wsbt_pkg::*;

    logic [DUTY_W-1:0]  ref_duty_reg;
    logic [SPEED_W-1:0] numerator_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_duty_reg  <= REF_DUTY_RESET;
            numerator_reg <= NUMERATOR_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_REF_DUTY:  ref_duty_reg  <= pwdata[DUTY_W-1:0];
                REG_SPEED_NUM: numerator_reg <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_REF_DUTY:  prdata = {{(PDATA_W-DUTY_W){1'b0}}, ref_duty_reg};
            REG_SPEED_NUM: prdata = {{(PDATA_W-SPEED_W){1'b0}}, numerator_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.ref_duty        = ref_duty_reg;
    assign cfg.speed_numerator = numerator_reg;

endmodule

// ----- hdl/wsbt_div.sv -----
// wsbt_div: shared restoring divider, one quotient bit per cycle
// depends on wsbt_pkg
`timescale 1ns / 1ps
module wsbt_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  wsbt_pkg::div_ctrl_t ctrl,
    output wsbt_pkg::div_stat_t stat
);
    import wsbt_pkg::*;

    localparam int CNT_W = $clog2(SPEED_W);

    logic [SPEED_W-1:0] rem_reg, rem_next;
    logic [SPEED_W-1:0] quo_reg, quo_next;
    logic [SPEED_W-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SPEED_W:0]   shifted;
    logic [SPEED_W:0]   diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[SPEED_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        if (!diff[SPEED_W]) begin
            rem_next = diff[SPEED_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[SPEED_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= ctrl.dividend;
                dsr_reg  <= ctrl.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SPEED_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule
